/* hw/rtl/sfcf_pkg.sv */
package sfcf_pkg;

    localparam int SAMPLE_WIDTH      = 24;
    localparam int GAIN_W            = 16;
    localparam int DLY_W             = 13;
    localparam int DEF_DELAY_DEPTH   = 8192;

    localparam int APB_ADDR_W        = 4;
    localparam int APB_DATA_W        = 32;

    localparam logic [APB_ADDR_W-3:0] REG_DELAY_LENGTH      = 2'd0;
    localparam logic [APB_ADDR_W-3:0] REG_FEEDBACK_GAIN     = 2'd1;
    localparam logic [APB_ADDR_W-3:0] REG_NEGATIVE_POLARITY = 2'd2;

    localparam logic [DLY_W-1:0]  RST_DELAY_LENGTH  = 13'd1;
    localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'd0;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } t_out;

    // per-cycle controls from the sequencer to each channel datapath
    typedef struct packed {
        logic rd_en;
        logic s1_fwd;
        logic s1_zero;
        logic s2_we;
        logic neg;
    } t_ch_ctl;

endpackage

/* hw/rtl/sfcf_channel.sv */
module sfcf_channel #(
    parameter int DELAY_DEPTH = sfcf_pkg::DEF_DELAY_DEPTH
) (
    input  logic                                     i_clk,
    input  sfcf_pkg::t_ch_ctl                        i_ctl,
    input  logic [sfcf_pkg::GAIN_W-1:0]              i_gain,
    input  logic [$clog2(DELAY_DEPTH)-1:0]           i_rd_addr,
    input  logic [$clog2(DELAY_DEPTH)-1:0]           i_wr_addr,
    input  logic signed [sfcf_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [sfcf_pkg::SAMPLE_WIDTH-1:0] o_result
);
    import sfcf_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = SW + GAIN_W + 1;
    localparam int TW = PW - GAIN_W;
    localparam int XW = SW + 2;

    localparam logic signed [PW-1:0] RND     = PW'(1) <<< (GAIN_W - 1);
    localparam logic signed [XW-1:0] SAT_MAX = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] SAT_MIN = -SAT_MAX - XW'(1);

    logic signed [SW-1:0] r_mem [DELAY_DEPTH];
    logic signed [SW-1:0] r_q;
    logic signed [SW-1:0] r_last;
    logic signed [SW-1:0] r_s1_in;
    logic signed [SW-1:0] r_s2_in;
    logic signed [PW-1:0] r_prod;

    logic signed [SW-1:0] delayed;
    logic signed [PW-1:0] rounded;
    logic signed [TW-1:0] term;
    logic signed [XW-1:0] sum;

    // delay store: read-before-write, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
        if (i_ctl.s2_we) begin
            r_mem[i_wr_addr] <= o_result;
        end
    end

    always_comb begin
        if (i_ctl.s1_fwd) begin
            delayed = r_last;
        end else if (i_ctl.s1_zero) begin
            delayed = '0;
        end else begin
            delayed = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_s1_in <= i_sample;
        end
        r_prod  <= PW'(delayed) * PW'($signed({1'b0, i_gain}));
        r_s2_in <= r_s1_in;
        if (i_ctl.s2_we) begin
            r_last <= o_result;
        end
    end

    // round half up (add half, then floor), add or subtract, then saturate
    always_comb begin
        rounded = r_prod + RND;
        term    = rounded[PW-1:GAIN_W];
        if (i_ctl.neg) begin
            sum = XW'(r_s2_in) - XW'(term);
        end else begin
            sum = XW'(r_s2_in) + XW'(term);
        end
        if (sum > SAT_MAX) begin
            o_result = SAT_MAX[SW-1:0];
        end else if (sum < SAT_MIN) begin
            o_result = SAT_MIN[SW-1:0];
        end else begin
            o_result = sum[SW-1:0];
        end
    end

endmodule

/* hw/rtl/stereo_feedback_comb_filter_top.sv */
// Stereo feedback comb filter: out = in +/- round(gain * delayed), saturated, per
// channel, with the delayed sample taken delay_length items back from a circular
// store of DELAY_DEPTH entries. One item is accepted per cycle while the output
// queue has room; when the effective delay is one, each item is held until the
// previous one has reached the add stage. Results pass the read and multiply
// registers and the add stage into a four-entry output queue. The stores read as
// zero until written (a fill flag tracks the first pass of the write pointer), so
// no clearing pass follows reset. Configuration is written over the APB port; the
// user must write it only while the block is idle; the block does not enforce it.
module stereo_feedback_comb_filter_top #(
    parameter int DELAY_DEPTH = sfcf_pkg::DEF_DELAY_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sfcf_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sfcf_pkg::t_out                     o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfcf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sfcf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sfcf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import sfcf_pkg::*;

    localparam int AW         = $clog2(DELAY_DEPTH);
    localparam int CW         = ((AW > DLY_W) ? AW : DLY_W) + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = FAW + 1;

    logic [DLY_W-1:0]  r_delay_length;
    logic [GAIN_W-1:0] r_gain;
    logic              r_neg;

    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     n_wp;
    logic              r_wrapped;
    logic              r_s1_v;
    logic              r_s2_v;
    logic [AW-1:0]     r_s1_wp;
    logic [AW-1:0]     r_s2_wp;
    logic              r_s1_fwd;
    logic              r_s1_zero;

    t_out              r_fifo [FIFO_DEPTH];
    logic [FAW-1:0]    r_rd_ptr;
    logic [FAW-1:0]    r_wr_ptr;
    logic [FCW-1:0]    r_count;
    logic [FCW-1:0]    n_count;

    logic              cfg_we;
    logic [CW-1:0]     d_ext;
    logic [CW-1:0]     d_eff;
    logic [CW-1:0]     wp_ext;
    logic [CW-1:0]     rd_ext;
    logic [AW-1:0]     rd_addr;
    logic              filled;
    logic              hazard;
    logic              fwd;
    logic              room;
    logic              accept;
    logic              push;
    logic              pop;
    t_ch_ctl           ctl;
    t_out              result;
    logic signed [SAMPLE_WIDTH-1:0] left_result;
    logic signed [SAMPLE_WIDTH-1:0] right_result;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= RST_DELAY_LENGTH;
            r_gain         <= RST_FEEDBACK_GAIN;
            r_neg          <= 1'b0;
        end else if (cfg_we) begin
            case (paddr[APB_ADDR_W-1:2])
                REG_DELAY_LENGTH:      r_delay_length <= pwdata[DLY_W-1:0];
                REG_FEEDBACK_GAIN:     r_gain         <= pwdata[GAIN_W-1:0];
                REG_NEGATIVE_POLARITY: r_neg          <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_ADDR_W-1:2])
            REG_DELAY_LENGTH:      prdata = APB_DATA_W'(r_delay_length);
            REG_FEEDBACK_GAIN:     prdata = APB_DATA_W'(r_gain);
            REG_NEGATIVE_POLARITY: prdata = APB_DATA_W'(r_neg);
            default:               prdata = '0;
        endcase
    end

    // read address: write pointer minus clamped delay, modulo depth
    always_comb begin
        d_ext = CW'(r_delay_length);
        if (d_ext == '0) begin
            d_eff = CW'(1);
        end else if (d_ext >= CW'(DELAY_DEPTH)) begin
            d_eff = CW'(DELAY_DEPTH - 1);
        end else begin
            d_eff = d_ext;
        end
        wp_ext = CW'(r_wp);
        filled = r_wrapped || (wp_ext >= d_eff);
        if (wp_ext >= d_eff) begin
            rd_ext = wp_ext - d_eff;
        end else begin
            rd_ext = wp_ext + CW'(DELAY_DEPTH) - d_eff;
        end
        rd_addr = rd_ext[AW-1:0];
    end

    assign hazard     = r_s1_v && (rd_addr == r_s1_wp);
    assign fwd        = r_s2_v && (rd_addr == r_s2_wp);
    assign room       = (r_count + FCW'(r_s1_v) + FCW'(r_s2_v)) < FCW'(FIFO_DEPTH);
    assign o_in_stall = !room || hazard;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_wp       = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            if (accept) begin
                r_wp <= n_wp;
                if (n_wp == '0) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_wp   <= r_wp;
            r_s1_fwd  <= fwd;
            r_s1_zero <= !filled;
        end
        r_s2_wp <= r_s1_wp;
    end

    always_comb begin
        ctl.rd_en   = accept;
        ctl.s1_fwd  = r_s1_fwd;
        ctl.s1_zero = r_s1_zero;
        ctl.s2_we   = r_s2_v;
        ctl.neg     = r_neg;
    end

    sfcf_channel #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_left (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_gain    (r_gain),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_s2_wp),
        .i_sample  (i_in_data.left_in),
        .o_result  (left_result)
    );

    sfcf_channel #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_right (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_gain    (r_gain),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_s2_wp),
        .i_sample  (i_in_data.right_in),
        .o_result  (right_result)
    );

    assign result = {left_result, right_result};

    // output queue
    assign push        = r_s2_v;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign n_count     = r_count + FCW'(push) - FCW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= result;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < FCW'(FIFO_DEPTH)) || pop)
        else $error("result pushed into full queue");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 r_s2_v)
        else $error("accepted item lost in pipeline");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_wp == (($past(r_wp) == AW'(DELAY_DEPTH - 1)) ? '0
                                                                   : $past(r_wp) + 1'b1)))
        else $error("write pointer did not advance by one");

    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && $past(accept) |-> !($past(r_s1_v) && ($past(rd_addr) == $past(r_s1_wp))))
        else $error("read issued against an unwritten in-flight result");

endmodule

/* sim/stereo_feedback_comb_filter_top_tb.sv */
module stereo_feedback_comb_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcf_pkg::*;

    localparam int                       DEPTH         = DEF_DELAY_DEPTH;
    localparam int                       SETTLE_CYCLES = 8;
    localparam logic [APB_ADDR_W-3:0]    REG_UNUSED    = 2'd3;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [GAIN_W-1:0]        GAIN_TOP      = 16'hFFFF;
    localparam logic [GAIN_W-1:0]        GAIN_RESONANT = 16'd62259;
    localparam logic [DLY_W-1:0]         DELAY_LONGEST = 13'd8191;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    t_in                     in_data   = '0;
    logic                    out_stall = 1'b0;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr     = '0;
    logic [APB_DATA_W-1:0]   pwdata    = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_stall;
    logic                    out_valid;
    t_out                    out_data;

    // comb filter state as the block should hold it
    logic signed [SAMPLE_WIDTH-1:0] left_hist  [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] right_hist [DEPTH];
    logic [DLY_W-1:0]               hist_wptr;
    logic [DLY_W-1:0]               cfg_delay;
    logic [GAIN_W-1:0]              cfg_gain;
    logic                           cfg_neg;

    t_out filtered_q [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_len  = 0;
    int hold_cnt  = 0;
    event hold_ev;

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatch_cnt  = 0;
    int orphan_cnt    = 0;
    int settings_cnt  = 0;
    int fail_cnt      = 0;

    stereo_feedback_comb_filter_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
    end

    initial forever begin
        @(hold_ev);
        for (int k = hold_len; k > 0; k--) begin
            hold_cnt <= k;
            @(posedge clk);
        end
        hold_cnt <= 0;
    end

    function automatic logic signed [SAMPLE_WIDTH-1:0] comb_tap(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [SAMPLE_WIDTH-1:0] past
    );
        longint prod;
        longint term;
        longint y;
        prod = longint'(past) * longint'(cfg_gain);
        term = (prod + 64'sd32768) >>> 16;
        y    = cfg_neg ? longint'(x) - term : longint'(x) + term;
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic predict_filtered(input t_in item);
        logic [DLY_W-1:0] dly;
        logic [DLY_W-1:0] rd;
        t_out             res;
        dly = (cfg_delay == '0) ? DLY_W'(1) : cfg_delay;
        rd  = hist_wptr - dly;
        res.left_out  = comb_tap(item.left_in,  left_hist[rd]);
        res.right_out = comb_tap(item.right_in, right_hist[rd]);
        left_hist[hist_wptr]  = res.left_out;
        right_hist[hist_wptr] = res.right_out;
        hist_wptr = hist_wptr + 1'b1;
        filtered_q.push_back(res);
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
                orphan_cnt++;
                $display("ERROR: unexpected result L=%0d R=%0d at %0t",
                         out_data.left_out, out_data.right_out, $realtime);
            end else begin
                want = filtered_q.pop_front();
                if (out_data.left_out !== want.left_out
                        || out_data.right_out !== want.right_out) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: result %0d exp L=%0d R=%0d got L=%0d R=%0d",
                                 results_seen, want.left_out, want.right_out,
                                 out_data.left_out, out_data.right_out);
                end
            end
        end
    end

    task automatic send_pair(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        items_sent++;
        predict_filtered(item);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-3:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DELAY_LENGTH:      cfg_delay = value[DLY_W-1:0];
            REG_FEEDBACK_GAIN:     cfg_gain  = value[GAIN_W-1:0];
            REG_NEGATIVE_POLARITY: cfg_neg   = value[0];
            default: ;
        endcase
        settings_cnt++;
    endtask

    task automatic set_filter(input logic [DLY_W-1:0] dly, input logic [GAIN_W-1:0] gain,
                              input logic neg, input logic junk);
        logic [APB_DATA_W-1:0] hi;
        hi = junk ? APB_DATA_W'($urandom) : '0;
        write_reg(REG_DELAY_LENGTH,      {hi[APB_DATA_W-1:DLY_W], dly});
        write_reg(REG_FEEDBACK_GAIN,     {hi[APB_DATA_W-1:GAIN_W], gain});
        write_reg(REG_NEGATIVE_POLARITY, {hi[APB_DATA_W-1:1], neg});
    endtask

    function automatic t_in pair(input logic signed [SAMPLE_WIDTH-1:0] l,
                                 input logic signed [SAMPLE_WIDTH-1:0] r);
        t_in p;
        p.left_in  = l;
        p.right_in = r;
        return p;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_WIDTH'($signed($urandom_range(512)) - 256);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_in rand_pair();
        return pair(rand_sample(), rand_sample());
    endfunction

    task automatic random_filter();
        logic [DLY_W-1:0]  dly;
        logic [GAIN_W-1:0] gain;
        case ($urandom_range(9))
            0:       dly = '0;
            1, 2:    dly = DLY_W'(1);
            3:       dly = DELAY_LONGEST;
            4, 5, 6: dly = DLY_W'($urandom_range(24, 2));
            default: dly = DLY_W'($urandom_range(700, 25));
        endcase
        case ($urandom_range(5))
            0:       gain = '0;
            1:       gain = GAIN_TOP;
            2:       gain = GAIN_RESONANT;
            default: gain = GAIN_W'($urandom);
        endcase
        set_filter(dly, gain, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic test_passthrough_extremes();
        send_pair(pair(SAMPLE_MAX, SAMPLE_MIN));
        send_pair(pair(SAMPLE_MIN, SAMPLE_MAX));
        send_pair(pair('0, -24'sd1));
        send_pair(pair(24'sh555555, 24'shAAAAAA));
        send_pair(pair(24'sd1, -24'sd2));
        drain();
    endtask

    task automatic test_delay_one_saturation();
        set_filter(DLY_W'(1), GAIN_TOP, 1'b0, 1'b0);
        repeat (3) send_pair(pair(SAMPLE_MAX, SAMPLE_MIN));
        drain();
        write_reg(REG_NEGATIVE_POLARITY, 32'd1);
        send_pair(pair(SAMPLE_MAX, SAMPLE_MIN));
        send_pair(pair(SAMPLE_MIN, SAMPLE_MAX));
        send_pair(pair(-24'sd1, 24'sd1));
        drain();
        // zero delay behaves as one
        set_filter('0, GAIN_RESONANT, 1'b0, 1'b0);
        send_pair(pair(SAMPLE_MAX, -24'sd1));
        send_pair(pair(24'sd1, SAMPLE_MIN));
        send_pair(pair(-24'sd3, 24'sd3));
        drain();
    endtask

    task automatic test_long_delay();
        set_filter(DELAY_LONGEST, GAIN_RESONANT, 1'b1, 1'b0);
        send_pair(pair(SAMPLE_MIN, SAMPLE_MAX));
        send_pair(pair(24'sd12345, -24'sd12345));
        drain();
        set_filter(DLY_W'(2), 16'h8000, 1'b1, 1'b0);
        repeat (3) send_pair(rand_pair());
        drain();
    endtask

    task automatic test_register_decode();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        set_filter(DLY_W'(3), 16'h4000, 1'b0, 1'b1);
        repeat (3) send_pair(rand_pair());
        drain();
    endtask

    task automatic test_output_backpressure();
        set_filter(DLY_W'(5), GAIN_RESONANT, 1'b0, 1'b0);
        idle_pct  = 0;
        stall_pct <= 0;
        hold_len  = 60;
        -> hold_ev;
        repeat (30) send_pair(rand_pair());
        drain();
        set_filter(DLY_W'(1), GAIN_TOP, 1'b1, 1'b0);
        hold_len = 40;
        -> hold_ev;
        repeat (20) send_pair(rand_pair());
        drain();
    endtask

    task automatic test_random_traffic();
        int idle_tbl  [4] = '{0, 64, 0, 30};
        int stall_tbl [4] = '{0, 0, 64, 30};
        for (int m = 0; m < 4; m++) begin
            for (int s = 0; s < 2; s++) begin
                random_filter();
                idle_pct  = idle_tbl[m];
                stall_pct <= stall_tbl[m];
                repeat (60) send_pair(rand_pair());
                drain();
            end
        end
        idle_pct  = 0;
        stall_pct <= 0;
    endtask

    initial begin
        foreach (left_hist[k]) begin
            left_hist[k]  = '0;
            right_hist[k] = '0;
        end
        hist_wptr = '0;
        cfg_delay = RST_DELAY_LENGTH;
        cfg_gain  = RST_FEEDBACK_GAIN;
        cfg_neg   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough_extremes();
        test_delay_one_saturation();
        test_long_delay();
        test_register_decode();
        test_output_backpressure();
        test_random_traffic();
        drain();
        fail_cnt = mismatch_cnt + orphan_cnt + filtered_q.size();
        $display("Ran %0d stereo items through %0d register writes; %0d results checked",
                 items_sent, settings_cnt, results_seen);
        $display("Covered saturation, delays 0/1/8191, both polarities, long output stalls");
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d unexpected results", mismatch_cnt, orphan_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", filtered_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
